// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the core RTL.
// Under SYNTHESIS the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on a given clock with an active-low reset.
`define ASSERT_AT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset.
`define ASSERT_CORE(name, prop, msg) \
  `ASSERT_AT(name, clk_i, rst_ni, prop, msg)

`else

`define ASSERT_AT(name, clk, rst_n, prop, msg)
`define ASSERT_CORE(name, prop, msg)

`endif

`endif

// ----- rtl/core/olist_pkg.sv -----
`timescale 1ns / 1ps

package olist_pkg;

  // Fixed field widths
  localparam int unsigned FuncW   = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 5;

  // Command codes
  localparam logic [FuncW-1:0] FUNC_INS_FRONT = 2'd0;
  localparam logic [FuncW-1:0] FUNC_INS_BACK  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_FIND      = 2'd2;
  localparam logic [FuncW-1:0] FUNC_DELETE    = 2'd3;

  // Status codes
  localparam logic [StatusW-1:0] ST_DONE      = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd2;

  typedef logic signed [ValueW-1:0] value_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    value_t           operand_value;
  } olist_in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PosW-1:0]    position;
    logic [PosW-1:0]    list_length;
  } olist_out_t;

  // Per-cell load controls
  typedef struct packed {
    logic take_op;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

// ----- rtl/core/olist_cell.sv -----
`timescale 1ns / 1ps

module olist_cell (
  input  logic                clk_i,
  input  olist_pkg::cell_ctl_t ctl_i,
  input  logic                live_i,
  input  olist_pkg::value_t   operand_i,
  input  olist_pkg::value_t   left_i,
  input  olist_pkg::value_t   right_i,
  input  logic                hit_before_i,
  output logic                hit_before_o,
  output logic                first_hit_o,
  output olist_pkg::value_t   value_o
);
  import olist_pkg::*;

  value_t value_q, value_d;
  logic   hit;

  // Compare the held entry against the operand
  assign hit          = live_i && (value_q == operand_i);
  assign first_hit_o  = hit && !hit_before_i;
  assign hit_before_o = hit || hit_before_i;
  assign value_o      = value_q;

  // Pick the next entry: operand, left neighbor, right neighbor or hold
  always_comb begin
    priority if (ctl_i.take_op) begin
      value_d = operand_i;
    end else if (ctl_i.take_left) begin
      value_d = left_i;
    end else if (ctl_i.take_right) begin
      value_d = right_i;
    end else begin
      value_d = value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ----- rtl/core/ordered_list_insert_find_delete_top.sv -----
`timescale 1ns / 1ps
// A request is captured into req_q at acceptance and its response is registered
// into rsp_q once the response slot is free, so out_stall_i can delay it.
// No new request is taken until the held one has executed in the single
// compare-and-shift step of the cell row.
// Reset: asynchronous, active low; the list is empty and no response is held.

`include "assert_macros.svh"

module ordered_list_insert_find_delete_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  olist_pkg::olist_in_t  in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output olist_pkg::olist_out_t out_rsp_o
);
  import olist_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  logic            busy_q;
  olist_in_t       req_q;
  logic            out_valid_q;
  olist_out_t      rsp_q, rsp_d;
  logic [CntW-1:0] count_q, count_d;

  logic exec, full, is_front, is_back, is_find, is_del, found;
  logic [CntW-1:0] hit_pos;

  value_t    cell_val   [CAPACITY];
  logic      first_hit  [CAPACITY];
  logic      hit_chain  [CAPACITY+1];
  cell_ctl_t cell_ctl   [CAPACITY];
  logic      cell_live  [CAPACITY];

  // Execute once a request is held and the response slot is free
  assign exec       = busy_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = busy_q;

  assign full     = (count_q == CapCnt);
  assign is_front = (req_q.func == FUNC_INS_FRONT);
  assign is_back  = (req_q.func == FUNC_INS_BACK);
  assign is_find  = (req_q.func == FUNC_FIND);
  assign is_del   = (req_q.func == FUNC_DELETE);

  assign hit_chain[0] = 1'b0;
  assign found        = hit_chain[CAPACITY];

  // Row of cells, entry i in cell i, match flag handed down the row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_live[i] = (CntW'(i) < count_q);
    assign cell_ctl[i]  = '{
      take_op:    exec && is_back && !full && (CntW'(i) == count_q),
      take_left:  exec && is_front && !full,
      take_right: exec && is_del && hit_chain[i+1]
    };

    olist_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (cell_ctl[i]),
      .live_i       (cell_live[i]),
      .operand_i    (req_q.operand_value),
      .left_i       ((i == 0) ? req_q.operand_value : cell_val[(i == 0) ? 0 : i-1]),
      .right_i      (cell_val[(i == CAPACITY-1) ? i : i+1]),
      .hit_before_i (hit_chain[i]),
      .hit_before_o (hit_chain[i+1]),
      .first_hit_o  (first_hit[i]),
      .value_o      (cell_val[i])
    );
  end

  // Encode the position of the first match
  always_comb begin
    hit_pos = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (first_hit[i]) begin
        hit_pos = hit_pos | CntW'(i + 1);
      end
    end
  end

  // Build the response and the new length
  always_comb begin
    logic [CntW-1:0] pos;
    logic [31:0]     pos_w, len_w;
    count_d = count_q;
    pos     = '0;
    rsp_d.status = ST_DONE;
    unique case (req_q.func)
      FUNC_INS_FRONT: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
          pos     = CntW'(1);
        end
      end
      FUNC_INS_BACK: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
          pos     = count_q + CntW'(1);
        end
      end
      FUNC_FIND: begin
        if (found) begin
          pos = hit_pos;
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      FUNC_DELETE: begin
        if (found) begin
          pos     = hit_pos;
          count_d = count_q - CntW'(1);
        end else begin
          rsp_d.status = ST_NOT_FOUND;
        end
      end
      default: begin
        rsp_d.status = ST_DONE;
      end
    endcase
    pos_w = 32'(pos);
    len_w = 32'(count_d);
    rsp_d.position    = pos_w[PosW-1:0];
    rsp_d.list_length = len_w[PosW-1:0];
  end

  // Hold the request until it executes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (!busy_q && in_valid_i) begin
      busy_q <= 1'b1;
    end else if (exec) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // Advance the length and the response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (exec) begin
      count_q     <= count_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // Checks
  `ASSERT_CORE(a_count_bound, count_q <= CapCnt, "length above capacity")
  `ASSERT_CORE(a_exec_resp, exec |=> out_valid_q, "executed request lost its response")
  `ASSERT_CORE(a_count_hold, !exec |=> $stable(count_q), "length changed without a request")
  `ASSERT_CORE(a_full_rsp, out_valid_q && rsp_q.status == ST_FULL |-> full, "bad full status")
  `ASSERT_CORE(a_find_keeps, exec && is_find |=> $stable(count_q), "find changed the length")

endmodule

// ----- bench/tb_ordered_list_insert_find_delete_top.sv -----
`timescale 1ns / 1ps

module tb_ordered_list_insert_find_delete_top;
  import olist_pkg::*;

  localparam int          Capacity   = 16;
  localparam int          NumRandom  = 800;
  localparam int          BurstLen   = 40;
  localparam int          CycleLimit = 200000;
  localparam int          QuietFrom  = 900;
  localparam int          QuietTo    = 1500;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  olist_in_t  in_req = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  olist_out_t out_rsp;

  // Request and response bookkeeping
  olist_in_t  pending_reqs[$];
  olist_out_t expected_rsps[$];
  value_t     list_vals[Capacity];
  int         list_len = 0;
  int         cycle_cnt = 0;
  int         err_cnt = 0;
  int         req_cnt = 0;
  int         rsp_cnt = 0;
  int         full_cnt = 0;
  int         miss_cnt = 0;
  logic       in_fire = 1'b0;
  logic       quiet;

  assign quiet = (cycle_cnt >= QuietFrom) && (cycle_cnt < QuietTo);

  ordered_list_insert_find_delete_top #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  always #10 clk_i = ~clk_i;

  // Apply one command to the shadow list and return the response it produces
  function automatic olist_out_t apply_list_command(olist_in_t req);
    olist_out_t rsp;
    int         hit;
    rsp.status   = ST_DONE;
    rsp.position = '0;
    hit = list_len;
    for (int i = 0; i < list_len; i++) begin
      if (hit == list_len && list_vals[i] == req.operand_value) hit = i;
    end
    case (req.func)
      FUNC_INS_FRONT: begin
        if (list_len >= Capacity) begin
          rsp.status = ST_FULL;
        end else begin
          for (int i = list_len; i > 0; i--) list_vals[i] = list_vals[i-1];
          list_vals[0] = req.operand_value;
          list_len++;
          rsp.position = 1;
        end
      end
      FUNC_INS_BACK: begin
        if (list_len >= Capacity) begin
          rsp.status = ST_FULL;
        end else begin
          list_vals[list_len] = req.operand_value;
          list_len++;
          rsp.position = list_len[PosW-1:0];
        end
      end
      FUNC_FIND: begin
        if (hit < list_len) rsp.position = PosW'(hit + 1);
        else rsp.status = ST_NOT_FOUND;
      end
      default: begin
        if (hit < list_len) begin
          rsp.position = PosW'(hit + 1);
          for (int i = hit; i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end else begin
          rsp.status = ST_NOT_FOUND;
        end
      end
    endcase
    rsp.list_length = list_len[PosW-1:0];
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic queue_request(input logic [FuncW-1:0] func, input value_t val);
    olist_in_t req;
    req.func          = func;
    req.operand_value = val;
    pending_reqs.push_back(req);
  endtask

  // Drive requests and response stall on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_fire) begin
        if (pending_reqs.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
          in_valid <= 1'b1;
          in_req   <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 10);
    end
  end

  // Sample both handshakes on the rising edge
  always @(posedge clk_i) begin
    olist_out_t exp_rsp;
    cycle_cnt <= cycle_cnt + 1;
    in_fire = rst_ni && in_valid && !in_stall;
    if (rst_ni && out_valid && !out_stall) begin
      rsp_cnt++;
      if (expected_rsps.size() == 0) begin
        report_mismatch($sformatf("unexpected response %p", out_rsp));
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_rsp.status != exp_rsp.status)
          report_mismatch($sformatf("status got %0d exp %0d",
                                    out_rsp.status, exp_rsp.status));
        if (out_rsp.position != exp_rsp.position)
          report_mismatch($sformatf("position got %0d exp %0d",
                                    out_rsp.position, exp_rsp.position));
        if (out_rsp.list_length != exp_rsp.list_length)
          report_mismatch($sformatf("list_length got %0d exp %0d",
                                    out_rsp.list_length, exp_rsp.list_length));
      end
    end
    if (in_fire) begin
      req_cnt++;
      exp_rsp = apply_list_command(in_req);
      if (exp_rsp.status == ST_FULL) full_cnt++;
      if (exp_rsp.status == ST_NOT_FOUND) miss_cnt++;
      expected_rsps.push_back(exp_rsp);
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_cnt, expected_rsps.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Build the request stream, release reset and wait for the drain
  initial begin
    value_t            pool[8];
    logic [FuncW-1:0]  func;
    value_t            val;
    int                ins_pct;
    pool = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1, 32'sd1, 32'sd5,
             32'sh5555_5555, 32'shaaaa_aaaa};

    // Empty list, extremes, duplicates
    queue_request(FUNC_FIND, 32'sd5);
    queue_request(FUNC_DELETE, 32'sd5);
    queue_request(FUNC_INS_FRONT, 32'sh8000_0000);
    queue_request(FUNC_INS_BACK, 32'sh7fff_ffff);
    queue_request(FUNC_INS_BACK, 32'sd5);
    queue_request(FUNC_INS_FRONT, 32'sd5);
    queue_request(FUNC_FIND, 32'sd5);
    queue_request(FUNC_DELETE, 32'sd5);
    queue_request(FUNC_FIND, 32'sd5);
    queue_request(FUNC_FIND, 32'sh7fff_ffff);
    // Fill to capacity with mixed ends, then hit the full case from both ends
    for (int i = 0; i < Capacity - 3; i++)
      queue_request((i % 2) ? FUNC_INS_FRONT : FUNC_INS_BACK, value_t'(i * 7 - 3));
    queue_request(FUNC_INS_FRONT, -32'sd1);
    queue_request(FUNC_INS_BACK, -32'sd1);
    queue_request(FUNC_DELETE, value_t'((Capacity - 4) * 7 - 3));
    queue_request(FUNC_DELETE, 32'sh8000_0000);

    // Random bursts that lean toward filling, draining or neither
    for (int n = 0; n < NumRandom; n++) begin
      if (n % BurstLen == 0) begin
        case ($urandom_range(0, 2))
          0:       ins_pct = 70;
          1:       ins_pct = 25;
          default: ins_pct = 50;
        endcase
      end
      if ($urandom_range(0, 99) < 10) begin
        func = FuncW'($urandom_range(0, 3));
      end else if ($urandom_range(0, 99) < ins_pct) begin
        func = $urandom_range(0, 1) ? FUNC_INS_BACK : FUNC_INS_FRONT;
      end else begin
        func = $urandom_range(0, 1) ? FUNC_FIND : FUNC_DELETE;
      end
      val = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, 7)] : value_t'($urandom);
      queue_request(func, val);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Ran %0d list commands, %0d responses checked in %0d cycles.",
             req_cnt, rsp_cnt, cycle_cnt);
    $display("Inserts refused on a full list: %0d, lookups or deletes that missed: %0d.",
             full_cnt, miss_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
